// ===== sv/bpc_pkg.sv =====
// bpc_pkg: types, field widths, command codes and a popcount helper for the binary plane classifier
// no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int FIELD_W  = 16;
    localparam int CMD_W    = 2;
    localparam int OUTIDX_W = 3;
    localparam int RADIUS_W = 5;
    localparam int CLASS_W  = 8;
    localparam int POP_W    = 5;
    localparam int SUM_W    = 7;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [OUTIDX_W-1:0] output_index;
        logic [FIELD_W-1:0]  key_bits;
        logic [RADIUS_W-1:0] radius;
        logic [FIELD_W-1:0]  sample_bits;
    } t_in;

    typedef struct packed {
        logic [CLASS_W-1:0] class_bits;
        logic               store_full;
    } t_out;

    function automatic logic [POP_W-1:0] f_popcount(input logic [FIELD_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== sv/binary_plane_classifier.sv =====
// binary plane classifier: node store in one ram, command sequencer and output stage
// clear, add, an unknown command and classify of an empty store put their transaction in the result buffer
// classify scans the store: the ram read port walks one stored node per cycle into bpc_eval
// one command at a time: a new one is taken only in idle with the result buffer empty
// a result buffer lets the next command in while the output waits
// reset empties the node store by zeroing the node count; ram contents are not cleared
`timescale 1ns / 1ps

module binary_plane_classifier #(
    parameter int INPUT_BITS    = 16,
    parameter int OUTPUT_COUNT  = 8,
    parameter int NODE_CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bpc_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bpc_pkg::t_out o_out
);
    import bpc_pkg::*;

    localparam int KEY_W = (INPUT_BITS < FIELD_W) ? INPUT_BITS : FIELD_W;
    localparam int AW    = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
    localparam int CW    = $clog2(NODE_CAPACITY + 1);
    localparam int MEM_W = KEY_W + RADIUS_W + OUTIDX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_addr, n_addr;
    logic [KEY_W-1:0]   r_sample, n_sample;
    logic [CLASS_W-1:0] r_acc, n_acc;
    logic               r_rd_v, n_rd_v;
    logic               r_hold_v, n_hold_v;
    t_out               r_hold, n_hold;
    logic               r_out_v, n_out_v;
    t_out               r_out, n_out;

    logic               accept;
    logic               is_full;
    logic               we;
    logic [MEM_W-1:0]   wdata;
    logic [MEM_W-1:0]   rdata;
    logic               hit_valid;
    logic [CLASS_W-1:0] hit;
    logic               last_addr;

    assign o_in_ready = (r_state == S_IDLE) && !r_hold_v;
    assign accept     = i_in_valid && o_in_ready;
    assign is_full    = (r_count == CW'(NODE_CAPACITY));
    assign we         = accept && (i_in.command == CMD_ADD) && !is_full;
    assign wdata      = {i_in.key_bits[KEY_W-1:0], i_in.radius, i_in.output_index};
    assign last_addr  = ((CW'(r_addr) + CW'(1)) == r_count);

    bpc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NODE_CAPACITY),
        .AW    (AW)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    bpc_eval #(
        .KEY_W        (KEY_W),
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_rd_v),
        .i_key          (rdata[MEM_W-1 -: KEY_W]),
        .i_radius       (rdata[OUTIDX_W +: RADIUS_W]),
        .i_output_index (rdata[OUTIDX_W-1:0]),
        .i_sample       (r_sample),
        .o_hit_valid    (hit_valid),
        .o_hit          (hit)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_addr   = r_addr;
        n_sample = r_sample;
        n_acc    = r_acc;
        n_rd_v   = (r_state == S_SCAN);
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_out_v  = r_out_v;
        n_out    = r_out;

        if (hit_valid) begin
            n_acc = r_acc | hit;
        end

        // output stage takes from the result buffer
        if (!r_out_v || i_out_ready) begin
            n_out_v = r_hold_v;
            n_out   = r_hold;
            if (r_hold_v) begin
                n_hold_v = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_hold = '0;
                    priority if (i_in.command == CMD_CLEAR) begin
                        n_count  = '0;
                        n_hold_v = 1'b1;
                    end else if (i_in.command == CMD_ADD) begin
                        n_hold_v = 1'b1;
                        if (is_full) begin
                            n_hold.store_full = 1'b1;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (i_in.command == CMD_CLASSIFY) begin
                        n_sample = i_in.sample_bits[KEY_W-1:0];
                        n_acc    = '0;
                        n_addr   = '0;
                        if (r_count == '0) begin
                            n_hold_v = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_hold_v = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_v && !hit_valid) begin
                    n_hold_v          = 1'b1;
                    n_hold.class_bits = r_acc;
                    n_hold.store_full = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_v   <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_v   <= n_rd_v;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
        r_addr   <= n_addr;
        r_sample <= n_sample;
        r_acc    <= n_acc;
        r_hold   <= n_hold;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// ===== sv/bpc_ram.sv =====
// bpc_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bpc_eval.sv =====
// bpc_eval: scores one stored node against the sample and registers its class hit
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_eval #(
    parameter int KEY_W        = 16,
    parameter int OUTPUT_COUNT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [KEY_W-1:0]               i_key,
    input  logic [bpc_pkg::RADIUS_W-1:0]   i_radius,
    input  logic [bpc_pkg::OUTIDX_W-1:0]   i_output_index,
    input  logic [KEY_W-1:0]               i_sample,
    output logic                           o_hit_valid,
    output logic [bpc_pkg::CLASS_W-1:0]    o_hit
);
    import bpc_pkg::*;

    localparam int OC_LIM_I = (OUTPUT_COUNT < CLASS_W) ? OUTPUT_COUNT : CLASS_W;
    localparam logic [OUTIDX_W:0] OC_LIM = (OUTIDX_W+1)'(OC_LIM_I);

    logic [FIELD_W-1:0] key_ext;
    logic [FIELD_W-1:0] smp_ext;
    logic [POP_W-1:0]   pos_cnt;
    logic [POP_W-1:0]   neg_cnt;
    logic [POP_W-1:0]   key_cnt;
    logic [SUM_W-1:0]   lhs;
    logic [SUM_W-1:0]   rhs;
    logic               fire;
    logic [CLASS_W-1:0] n_hit;
    logic [CLASS_W-1:0] r_hit;
    logic               r_hit_valid;

    // fire when pos - neg >= popcount(key) - radius, kept unsigned, and the output index is below the output limit
    always_comb begin
        key_ext = FIELD_W'(i_key);
        smp_ext = FIELD_W'(i_sample);
        pos_cnt = f_popcount(smp_ext & key_ext);
        neg_cnt = f_popcount(smp_ext & ~key_ext);
        key_cnt = f_popcount(key_ext);
        lhs     = SUM_W'(pos_cnt) + SUM_W'(i_radius);
        rhs     = SUM_W'(neg_cnt) + SUM_W'(key_cnt);
        fire    = (lhs >= rhs) && ({1'b0, i_output_index} < OC_LIM);
        n_hit   = fire ? (CLASS_W'(1) << i_output_index) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_valid <= 1'b0;
        end else begin
            r_hit_valid <= i_valid;
        end
        r_hit <= n_hit;
    end

    assign o_hit_valid = r_hit_valid;
    assign o_hit       = r_hit;

endmodule
